@@ rtl/core/ppmg_pkg.sv @@
// ----------------------------------------------------------------------------
// ppmg_pkg
// shared types and constants of the ppm frame generator
// ----------------------------------------------------------------------------
package ppmg_pkg;

   // register indexes of the configuration port
   localparam logic [1:0] CSR_FRAME_TICKS = 2'd0;
   localparam logic [1:0] CSR_PULSE_TICKS = 2'd1;
   localparam logic [1:0] CSR_ACTIVE_HIGH = 2'd2;

   // reset values
   localparam logic [15:0] FRAME_RESET  = 16'd22500;
   localparam logic [11:0] PULSE_RESET  = 12'd300;
   localparam logic        ACTIVE_RESET = 1'b1;
   localparam logic [11:0] WIDTH_RESET  = 12'd1000;

   // request kinds carried on tuser
   localparam logic FUNC_TICK  = 1'b0;
   localparam logic FUNC_WRITE = 1'b1;

   // one result, last field in the lowest bit
   typedef struct packed {
      logic bad_index;
      logic sync_gap;
      logic edge_event;
      logic ppm_level;
   } rsp_type;

endpackage

@@ rtl/core/ppmg_ram.sv @@
// ----------------------------------------------------------------------------
// ppmg_ram
// generic single write port ram with one registered read port
// ----------------------------------------------------------------------------
module ppmg_ram #(
   parameter int WIDTH = 12,
   parameter int DEPTH = 6,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/ppmg_out_queue.sv @@
// ----------------------------------------------------------------------------
// ppmg_out_queue
// two-entry result queue between the frame logic and the response channel
// ----------------------------------------------------------------------------
module ppmg_out_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  ppmg_pkg::rsp_type push_data,
   output logic             push_ready,
   output logic             out_valid,
   input  logic             out_ready,
   output ppmg_pkg::rsp_type out_data
);

   import ppmg_pkg::*;

   rsp_type    head_ff, head_in;
   rsp_type    tail_ff, tail_in;
   logic [1:0] count_ff, count_in;
   logic       pop;

   assign pop        = (count_ff != 2'd0) && out_ready;
   assign push_ready = (count_ff != 2'd2);
   assign out_valid  = (count_ff != 2'd0);
   assign out_data   = head_ff;

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (pop) begin
         if (count_ff == 2'd2) begin
            head_in = tail_ff;
         end else begin
            head_in = push_data;
         end
      end else if (count_ff == 2'd0) begin
         head_in = push_data;
      end
      // second slot only fills when the head stays occupied
      if (push && (((count_ff == 2'd1) && !pop) || ((count_ff == 2'd2) && pop))) begin
         tail_in = push_data;
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + 2'd1;
         2'b01:   count_in = count_ff - 2'd1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
      head_ff <= head_in;
      tail_ff <= tail_in;
   end

endmodule

@@ rtl/core/ppm_frame_generator.sv @@
// ----------------------------------------------------------------------------
// ppm_frame_generator
// radio-control ppm frame generator: channel widths held in a ram, a
// microsecond countdown alternating marker pulses with channel gaps
// ----------------------------------------------------------------------------
//
//  port group | direction | payload
//  -----------+-----------+------------------------------------------------
//  req_       | in        | tdata: chan_index, chan_width; tuser: func
//  rsp_       | out       | tdata: ppm_level, edge_event, sync_gap, bad_index
//  csr_       | in        | write enable, index, data (no read-back)
//
//  one request per clock while req_tready is high; each request is handled
//  in the cycle it is taken; the width of the channel due next is prefetched
//  from the ram, a write to that same entry is bypassed through a small register
//  reset is synchronous; per-entry valid bits make unwritten widths read as
//  1000, so no clearing pass is needed
//  results wait in a two-entry queue; req_tready falls only when it is full
//
module ppm_frame_generator #(
   parameter int CHANNELS    = 6,
   parameter int START_DELAY = 50
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [3:0] chan_index, [15:4] chan_width
   input  logic        req_tuser,   // [0] func
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [0] ppm_level, [1] edge_event,
                                    // [2] sync_gap, [3] bad_index, [7:4] zero
   // configuration port
   input  logic        csr_we,
   input  logic [1:0]  csr_addr,
   input  logic [15:0] csr_wdata
);

   import ppmg_pkg::*;

   localparam int ADDR_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int POS_W  = $clog2(CHANNELS + 1);

   // configuration registers
   logic [15:0] frame_ticks_ff;
   logic [11:0] pulse_ticks_ff;
   logic        active_high_ff;

   // frame state
   logic [15:0]      countdown_ff, countdown_in;
   logic             pulse_next_ff, pulse_next_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [16:0]      width_sum_ff, width_sum_in;
   logic             level_ff, level_in;
   logic             in_sync_ff, in_sync_in;

   // width store bookkeeping
   logic [CHANNELS-1:0] valid_ff;
   logic                rd_valid_ff;
   logic                fwd_hit_ff;
   logic [11:0]         fwd_data_ff;
   logic [11:0]         ram_rdata;
   logic [ADDR_W-1:0]   rd_addr;
   logic [ADDR_W-1:0]   wr_addr;
   logic                wr_en;

   // request fields
   logic        accept;
   logic        func;
   logic [3:0]  chan_index;
   logic [11:0] chan_width;
   logic        index_ok;

   // event arithmetic
   logic [11:0] cur_width;
   logic [16:0] total;
   logic [15:0] chan_gap;
   logic [15:0] sync_len;
   logic        fire;
   logic        push_ready;
   rsp_type     result;
   rsp_type     rsp_head;

   assign func       = req_tuser;
   assign chan_index = req_tdata[3:0];
   assign chan_width = req_tdata[15:4];
   assign accept     = req_tvalid && req_tready;
   assign req_tready = push_ready;

   assign index_ok = ({1'b0, chan_index} < 5'(CHANNELS));
   assign wr_en    = accept && (func == FUNC_WRITE) && index_ok;
   assign wr_addr  = chan_index[ADDR_W-1:0];

   // prefetched width of the current channel; unwritten entries read as reset
   assign cur_width = fwd_hit_ff  ? fwd_data_ff :
                      rd_valid_ff ? ram_rdata   : WIDTH_RESET;

   // channel gap: width less the pulse, at least one tick
   assign chan_gap = (cur_width > pulse_ticks_ff) ?
                     {4'd0, cur_width - pulse_ticks_ff} : 16'd1;

   // sync gap: what is left of the frame after the widths and one pulse
   assign total    = width_sum_ff + {5'd0, pulse_ticks_ff};
   assign sync_len = ({1'b0, frame_ticks_ff} > total) ?
                     16'({1'b0, frame_ticks_ff} - total) : 16'd1;

   assign fire = accept && (func == FUNC_TICK) && (countdown_ff <= 16'd1);

   always_comb begin
      countdown_in  = countdown_ff;
      pulse_next_in = pulse_next_ff;
      pos_in        = pos_ff;
      width_sum_in  = width_sum_ff;
      level_in      = level_ff;
      in_sync_in    = in_sync_ff;
      if (fire) begin
         if (pulse_next_ff) begin
            // marker pulse starts
            level_in      = 1'b1;
            pulse_next_in = 1'b0;
            in_sync_in    = 1'b0;
            countdown_in  = (pulse_ticks_ff == 12'd0) ? 16'd1 : {4'd0, pulse_ticks_ff};
         end else begin
            level_in      = 1'b0;
            pulse_next_in = 1'b1;
            if ({{(32-POS_W){1'b0}}, pos_ff} >= 32'(CHANNELS)) begin
               // all channels sent: long gap closes the frame
               pos_in       = '0;
               countdown_in = sync_len;
               width_sum_in = '0;
               in_sync_in   = 1'b1;
            end else begin
               countdown_in = chan_gap;
               width_sum_in = width_sum_ff + {5'd0, cur_width};
               pos_in       = pos_ff + POS_W'(1);
               in_sync_in   = 1'b0;
            end
         end
      end else if (accept && (func == FUNC_TICK)) begin
         countdown_in = countdown_ff - 16'd1;
      end
   end

   // read address follows the channel position of the next cycle
   assign rd_addr = ({{(32-POS_W){1'b0}}, pos_in} < 32'(CHANNELS)) ?
                    pos_in[ADDR_W-1:0] : '0;

   ppmg_ram #(
      .WIDTH (12),
      .DEPTH (CHANNELS)
   ) u_width_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (chan_width),
      .rd_addr (rd_addr),
      .rd_data (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_ticks_ff <= FRAME_RESET;
         pulse_ticks_ff <= PULSE_RESET;
         active_high_ff <= ACTIVE_RESET;
         countdown_ff   <= 16'(START_DELAY);
         pulse_next_ff  <= 1'b1;
         pos_ff         <= '0;
         width_sum_ff   <= '0;
         level_ff       <= 1'b0;
         in_sync_ff     <= 1'b0;
         valid_ff       <= '0;
         rd_valid_ff    <= 1'b0;
         fwd_hit_ff     <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_addr)
               CSR_FRAME_TICKS: frame_ticks_ff <= csr_wdata;
               CSR_PULSE_TICKS: pulse_ticks_ff <= csr_wdata[11:0];
               CSR_ACTIVE_HIGH: active_high_ff <= csr_wdata[0];
               default:         ;
            endcase
         end
         countdown_ff  <= countdown_in;
         pulse_next_ff <= pulse_next_in;
         pos_ff        <= pos_in;
         width_sum_ff  <= width_sum_in;
         level_ff      <= level_in;
         in_sync_ff    <= in_sync_in;
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         // the ram returns old data when read and written together
         rd_valid_ff <= valid_ff[rd_addr];
         fwd_hit_ff  <= wr_en && (wr_addr == rd_addr);
      end
      fwd_data_ff <= chan_width;
   end

   // result of this request, pin level through the polarity setting
   always_comb begin
      result.ppm_level  = level_in ^ ~active_high_ff;
      result.edge_event = fire;
      result.sync_gap   = in_sync_in;
      result.bad_index  = accept && (func == FUNC_WRITE) && !index_ok;
   end

   ppmg_out_queue u_out_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (accept),
      .push_data  (result),
      .push_ready (push_ready),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_data   (rsp_head)
   );

   assign rsp_tdata = {4'd0, rsp_head};

endmodule
